// ===== rtl/page_hotness_tracker_defines.svh =====
// Assertion macros shared by the page hotness tracker checkers.
`ifndef PAGE_HOTNESS_TRACKER_DEFINES_SVH
`define PAGE_HOTNESS_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PHT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("page hotness tracker check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define PHT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("page hotness tracker check failed");

`endif

// ===== rtl/pht_pkg.sv =====
// Shared types, codes and constants of the page hotness tracker.
package pht_pkg;

   localparam int PAGES_DEF      = 4096;
   localparam int COUNT_BITS_DEF = 16;
   localparam int PN_W           = 12;
   localparam int OP_W           = 3;
   localparam int LIM_W          = 16;
   localparam int CNT_OUT_W      = 16;
   localparam int STAMP_W        = 32;
   localparam int CSR_IDX_W      = 2;

   localparam logic [OP_W-1:0] OPC_REGISTER = 3'd0;
   localparam logic [OP_W-1:0] OPC_READ     = 3'd1;
   localparam logic [OP_W-1:0] OPC_WRITE    = 3'd2;
   localparam logic [OP_W-1:0] OPC_HOT_POP  = 3'd3;
   localparam logic [OP_W-1:0] OPC_COLD_POP = 3'd4;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_HOT  = 2'd1;
   localparam logic [1:0] PUSH_COLD = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNTRACKED = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HOT_READ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_WRITE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLING   = 2'd2;

   typedef enum logic [2:0] {
      KIND_REGISTER,
      KIND_READ,
      KIND_WRITE,
      KIND_HOT_POP,
      KIND_COLD_POP,
      KIND_NONE
   } op_kind_type;

   typedef struct packed {
      op_kind_type     kind;
      logic            in_range;
      logic [PN_W-1:0] page;
   } work_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [LIM_W-1:0] hot_read_limit;
      logic [LIM_W-1:0] hot_write_limit;
      logic [LIM_W-1:0] cooling_limit;
   } limits_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

endpackage

// ===== rtl/pht_queue.sv =====
// Two-entry queue between the request front end and the table back end.
module pht_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pht_pkg::work_item_type    push_item,
   input  logic                      pop,
   output pht_pkg::work_item_type    pop_item,
   output pht_pkg::queue_status_type status
);

   pht_pkg::work_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = slot_ff[rd_ptr_ff];
   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;

endmodule

// ===== rtl/pht_front.sv =====
// Request front end: handshake and op decode into queue items.
module pht_front #(
   parameter int PAGES = pht_pkg::PAGES_DEF
) (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pht_pkg::OP_W-1:0]    req_op,
   input  logic [pht_pkg::PN_W-1:0]    req_page_number,
   input  pht_pkg::queue_status_type   q_status,
   input  logic                        clearing,
   output logic                        push,
   output pht_pkg::work_item_type      push_item
);

   assign req_ready = !q_status.full && !clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_item.page     = req_page_number;
      push_item.in_range = 32'(req_page_number) < 32'(PAGES);
      case (req_op)
         pht_pkg::OPC_REGISTER: push_item.kind = pht_pkg::KIND_REGISTER;
         pht_pkg::OPC_READ:     push_item.kind = pht_pkg::KIND_READ;
         pht_pkg::OPC_WRITE:    push_item.kind = pht_pkg::KIND_WRITE;
         pht_pkg::OPC_HOT_POP:  push_item.kind = pht_pkg::KIND_HOT_POP;
         pht_pkg::OPC_COLD_POP: push_item.kind = pht_pkg::KIND_COLD_POP;
         default:               push_item.kind = pht_pkg::KIND_NONE;
      endcase
   end

endmodule

// ===== rtl/pht_back.sv =====
// Back end: page table memory, read-modify-write per request, result register.
module pht_back #(
   parameter int PAGES      = pht_pkg::PAGES_DEF,
   parameter int COUNT_BITS = pht_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pht_pkg::limits_type              limits,
   input  pht_pkg::queue_status_type        q_status,
   input  pht_pkg::work_item_type           pop_item,
   output logic                             pop,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pht_pkg::PN_W-1:0]         rsp_page_id,
   output logic [1:0]                       rsp_ring_push,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_cool_request,
   output logic [pht_pkg::CNT_OUT_W-1:0]    rsp_read_count,
   output logic [pht_pkg::CNT_OUT_W-1:0]    rsp_write_count
);

   localparam int IDX_W  = $clog2(PAGES);
   localparam int EW     = 3 + 2 * COUNT_BITS + pht_pkg::STAMP_W;
   localparam int RD_LO  = 3;
   localparam int WR_LO  = 3 + COUNT_BITS;
   localparam int STP_LO = 3 + 2 * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // entry: [0] tracked, [1] hot, [2] queued, read count, write count, stamp
   logic [EW-1:0] mem [PAGES];
   logic [EW-1:0] rdata_ff;

   pht_pkg::back_state_type state_ff, state_in;
   pht_pkg::work_item_type  item_ff;
   logic [IDX_W-1:0]        clr_idx_ff, clr_idx_in;
   logic [pht_pkg::STAMP_W-1:0] epoch_ff, epoch_in;
   logic [31:0]             untracked_ff, untracked_in;
   logic [31:0]             samples_ff, samples_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [pht_pkg::PN_W-1:0] page_ff;
   logic [1:0]              push_ff, status_ff;
   logic                    cool_ff;
   logic [pht_pkg::CNT_OUT_W-1:0] rd_out_ff, wr_out_ff;

   logic             out_free, load, mem_we;
   logic [IDX_W-1:0] waddr;
   logic [EW-1:0]    wdata;

   // computed result of the current request
   logic [EW-1:0]    new_entry;
   logic [1:0]       push_val, status_val;
   logic             cool_val, trk_out, bump_untracked, bump_samples;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clearing = state_ff == pht_pkg::BACK_CLEAR;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pht_pkg::BACK_CLEAR: if (clr_idx_ff == IDX_W'(PAGES - 1)) state_in = pht_pkg::BACK_IDLE;
         pht_pkg::BACK_IDLE:  if (!q_status.empty) state_in = pht_pkg::BACK_EXEC;
         pht_pkg::BACK_EXEC:  if (out_free) state_in = pht_pkg::BACK_IDLE;
         default:             state_in = pht_pkg::BACK_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      pop    = 1'b0;
      load   = 1'b0;
      mem_we = 1'b0;
      waddr  = IDX_W'(item_ff.page);
      wdata  = new_entry;
      case (state_ff)
         pht_pkg::BACK_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_idx_ff;
            wdata  = '0;
         end
         pht_pkg::BACK_IDLE: pop = !q_status.empty;
         pht_pkg::BACK_EXEC: begin
            load   = out_free;
            mem_we = out_free && item_ff.in_range;
         end
         default: pop = 1'b0;
      endcase
   end

   // per-request datapath on the entry just read
   always_comb begin
      logic                  trk, hot, queued, is_hot;
      logic [COUNT_BITS-1:0] rd, wr, acc, cooled;
      logic [31:0]           age;
      trk    = item_ff.in_range && rdata_ff[0];
      hot    = rdata_ff[1];
      queued = rdata_ff[2];
      rd     = rdata_ff[RD_LO +: COUNT_BITS];
      wr     = rdata_ff[WR_LO +: COUNT_BITS];
      age    = epoch_ff - rdata_ff[STP_LO +: pht_pkg::STAMP_W];
      acc    = '0;
      cooled = '0;
      is_hot = 1'b0;
      new_entry      = rdata_ff;
      push_val       = pht_pkg::PUSH_NONE;
      status_val     = pht_pkg::ST_OK;
      cool_val       = 1'b0;
      trk_out        = trk;
      bump_untracked = 1'b0;
      bump_samples   = 1'b0;
      epoch_in       = epoch_ff;
      case (item_ff.kind)
         pht_pkg::KIND_REGISTER: begin
            if (!item_ff.in_range) begin
               status_val = pht_pkg::ST_UNTRACKED;
            end else if (trk) begin
               status_val = pht_pkg::ST_DUPLICATE;
            end else begin
               new_entry    = '0;
               new_entry[0] = 1'b1;
               trk_out      = 1'b1;
            end
         end
         pht_pkg::KIND_READ, pht_pkg::KIND_WRITE: begin
            if (!trk) begin
               status_val     = pht_pkg::ST_UNTRACKED;
               bump_untracked = 1'b1;
            end else begin
               acc = (item_ff.kind == pht_pkg::KIND_READ) ? rd : wr;
               if (acc != CNT_MAX) acc = acc + 1'b1;
               if (item_ff.kind == pht_pkg::KIND_READ) rd = acc;
               else wr = acc;
               is_hot = (32'(rd) >= 32'(limits.hot_read_limit)) ||
                        (32'(wr) >= 32'(limits.hot_write_limit));
               if (is_hot) begin
                  if (!hot || !queued) begin
                     queued   = 1'b1;
                     push_val = pht_pkg::PUSH_HOT;
                  end
               end else if (hot || !queued) begin
                  queued   = 1'b1;
                  push_val = pht_pkg::PUSH_COLD;
               end
               // lazy cooling: halve once per epoch step since the last stamp
               cooled = (age >= 32'(COUNT_BITS)) ? '0 : (acc >> age);
               if (item_ff.kind == pht_pkg::KIND_READ) rd = cooled;
               else wr = cooled;
               new_entry[2]                          = queued;
               new_entry[RD_LO +: COUNT_BITS]        = rd;
               new_entry[WR_LO +: COUNT_BITS]        = wr;
               new_entry[STP_LO +: pht_pkg::STAMP_W] = epoch_ff;
               if (32'(cooled) > 32'(limits.cooling_limit)) begin
                  epoch_in = epoch_ff + 1'b1;
                  cool_val = 1'b1;
               end
               bump_samples = 1'b1;
            end
         end
         pht_pkg::KIND_HOT_POP, pht_pkg::KIND_COLD_POP: begin
            if (!trk) begin
               status_val = pht_pkg::ST_UNTRACKED;
            end else begin
               new_entry[2] = 1'b0;
               new_entry[1] = item_ff.kind == pht_pkg::KIND_HOT_POP;
            end
         end
         default: status_val = pht_pkg::ST_OK;
      endcase
   end

   always_comb begin
      clr_idx_in   = clearing ? clr_idx_ff + 1'b1 : clr_idx_ff;
      untracked_in = (load && bump_untracked) ? untracked_ff + 1'b1 : untracked_ff;
      samples_in   = (load && bump_samples) ? samples_ff + 1'b1 : samples_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (pop) begin
         rdata_ff <= mem[IDX_W'(pop_item.page)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pht_pkg::BACK_CLEAR;
         clr_idx_ff   <= '0;
         epoch_ff     <= '0;
         untracked_ff <= '0;
         samples_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         if (load) epoch_ff <= epoch_in;
         untracked_ff <= untracked_in;
         samples_ff   <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
      if (load) begin
         page_ff   <= item_ff.page;
         push_ff   <= push_val;
         status_ff <= status_val;
         cool_ff   <= cool_val;
         rd_out_ff <= trk_out ?
            pht_pkg::CNT_OUT_W'(new_entry[RD_LO +: COUNT_BITS]) : '0;
         wr_out_ff <= trk_out ?
            pht_pkg::CNT_OUT_W'(new_entry[WR_LO +: COUNT_BITS]) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_id      = page_ff;
   assign rsp_ring_push    = push_ff;
   assign rsp_status       = status_ff;
   assign rsp_cool_request = cool_ff;
   assign rsp_read_count   = rd_out_ff;
   assign rsp_write_count  = wr_out_ff;

endmodule

// ===== rtl/page_hotness_tracker.sv =====
// Page hotness tracker top level: config registers, front end, queue, back end.
// A request is queued, popped with its table read, then written back with its
// response registered; the next is popped only once that is done and unstalled.
// After reset the table is cleared one entry per cycle;
// req_ready stays low meanwhile, config writes are taken at any time.
module page_hotness_tracker #(
   parameter int PAGES      = pht_pkg::PAGES_DEF,
   parameter int COUNT_BITS = pht_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pht_pkg::OP_W-1:0]         req_op,
   input  logic [pht_pkg::PN_W-1:0]         req_page_number,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pht_pkg::PN_W-1:0]         rsp_page_id,
   output logic [1:0]                       rsp_ring_push,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_cool_request,
   output logic [pht_pkg::CNT_OUT_W-1:0]    rsp_read_count,
   output logic [pht_pkg::CNT_OUT_W-1:0]    rsp_write_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pht_pkg::LIM_W-1:0]        csr_wdata
);

   pht_pkg::limits_type       limits_ff, limits_in;
   pht_pkg::queue_status_type q_status;
   pht_pkg::work_item_type    push_item, pop_item;
   logic                      push, pop, clearing;

   assign csr_ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         case (csr_index)
            pht_pkg::CSR_HOT_READ:  limits_in.hot_read_limit  = csr_wdata;
            pht_pkg::CSR_HOT_WRITE: limits_in.hot_write_limit = csr_wdata;
            pht_pkg::CSR_COOLING:   limits_in.cooling_limit   = csr_wdata;
            default:                limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.hot_read_limit  <= pht_pkg::LIM_W'(1);
         limits_ff.hot_write_limit <= pht_pkg::LIM_W'(1);
         limits_ff.cooling_limit   <= pht_pkg::LIM_W'(1);
      end else begin
         limits_ff <= limits_in;
      end
   end

   pht_front #(.PAGES(PAGES)) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_page_number (req_page_number),
      .q_status        (q_status),
      .clearing        (clearing),
      .push            (push),
      .push_item       (push_item)
   );

   pht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   pht_back #(.PAGES(PAGES), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .limits           (limits_ff),
      .q_status         (q_status),
      .pop_item         (pop_item),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_page_id      (rsp_page_id),
      .rsp_ring_push    (rsp_ring_push),
      .rsp_status       (rsp_status),
      .rsp_cool_request (rsp_cool_request),
      .rsp_read_count   (rsp_read_count),
      .rsp_write_count  (rsp_write_count)
   );

endmodule

// ===== rtl/pht_checker.sv =====
// Port-level checks of the page hotness tracker, bound to the top level.
`include "page_hotness_tracker_defines.svh"

module pht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pht_pkg::PN_W-1:0]      rsp_page_id,
   input logic [1:0]                    rsp_ring_push,
   input logic [1:0]                    rsp_status,
   input logic                          rsp_cool_request,
   input logic [pht_pkg::CNT_OUT_W-1:0] rsp_read_count,
   input logic [pht_pkg::CNT_OUT_W-1:0] rsp_write_count
);

   // only a tracked sample may push or request cooling
   `PHT_ASSERT_NOW(a_err_no_side_effect, rsp_valid && rsp_status != pht_pkg::ST_OK, rsp_ring_push == pht_pkg::PUSH_NONE && !rsp_cool_request)
   // untracked or out-of-range pages report zero counts
   `PHT_ASSERT_NOW(a_untracked_zero, rsp_valid && rsp_status == pht_pkg::ST_UNTRACKED, rsp_read_count == '0 && rsp_write_count == '0)
   // a stalled response holds its payload
   `PHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_page_id) && $stable(rsp_status))
   `PHT_ASSERT_NOW(a_push_code, rsp_valid, rsp_ring_push != 2'd3 && rsp_status != 2'd3)

endmodule

bind page_hotness_tracker pht_checker u_pht_checker (.*);
